@@ hdl/clns_pkg.sv @@
// shared types, constants and step tables for the character lcd nibble sequencer
package clns_pkg;

  localparam int unsigned OpcodeWidth = 2;
  localparam int unsigned ByteWidth   = 8;
  localparam int unsigned NibbleWidth = 4;
  localparam int unsigned TpuWidth    = 10;
  localparam int unsigned StepWidth   = 5;
  localparam int unsigned UsWidth     = 14;
  localparam int unsigned DelayWidth  = 24;

  localparam logic [TpuWidth-1:0] TpuReset = TpuWidth'(100);

  localparam logic [StepWidth-1:0] StepIdle      = StepWidth'(0);
  localparam logic [StepWidth-1:0] StepInitFirst = StepWidth'(1);
  localparam logic [StepWidth-1:0] StepInitLast  = StepWidth'(15);
  localparam logic [StepWidth-1:0] StepByteFirst = StepWidth'(16);
  localparam logic [StepWidth-1:0] StepLast      = StepWidth'(22);

  localparam logic [ByteWidth-1:0] InitFunctionSet = 8'h28;
  localparam logic [ByteWidth-1:0] InitDisplayOn   = 8'h0C;
  localparam logic [ByteWidth-1:0] InitEntryMode   = 8'h06;
  localparam logic [ByteWidth-1:0] InitClear       = 8'h01;

  localparam logic [NibbleWidth-1:0] NibbleWake  = 4'h3;
  localparam logic [NibbleWidth-1:0] NibbleFour  = 4'h2;
  localparam logic [NibbleWidth-1:0] NibbleNone  = 4'h0;

  typedef enum logic [1:0] {
    OpTick = 2'd0,
    OpCmd  = 2'd1,
    OpData = 2'd2,
    OpInit = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    KindIdle  = 3'd0,
    KindWait  = 3'd1,
    KindSetup = 3'd2,
    KindHigh  = 3'd3,
    KindLow   = 3'd4
  } step_kind_e;

  typedef struct packed {
    logic                   register_select;
    logic                   enable_pin;
    logic [NibbleWidth-1:0] data_nibble;
    logic                   busy_res;
    logic                   rejected;
  } res_t;

  function automatic step_kind_e step_kind(input logic [StepWidth-1:0] s);
    step_kind_e k;
    unique case (s)
      5'd1, 5'd5, 5'd9, 5'd22:                     k = KindWait;
      5'd2, 5'd6, 5'd10, 5'd13, 5'd16, 5'd19:      k = KindSetup;
      5'd3, 5'd7, 5'd11, 5'd14, 5'd17, 5'd20:      k = KindHigh;
      5'd4, 5'd8, 5'd12, 5'd15, 5'd18, 5'd21:      k = KindLow;
      default:                                     k = KindIdle;
    endcase
    return k;
  endfunction

  // length of a timed step in microseconds
  function automatic logic [UsWidth-1:0] step_us(input logic [StepWidth-1:0] s);
    logic [UsWidth-1:0] u;
    unique case (s)
      5'd1:                                    u = UsWidth'(15000);
      5'd5:                                    u = UsWidth'(5000);
      5'd9:                                    u = UsWidth'(100);
      5'd22:                                   u = UsWidth'(2000);
      5'd3, 5'd7, 5'd11, 5'd14, 5'd17, 5'd20:  u = UsWidth'(1);
      5'd4, 5'd8, 5'd12, 5'd15, 5'd18, 5'd21:  u = UsWidth'(50);
      default:                                 u = UsWidth'(0);
    endcase
    return u;
  endfunction

  function automatic logic [NibbleWidth-1:0] init_nibble(input logic [StepWidth-1:0] s);
    logic [NibbleWidth-1:0] n;
    unique case (s)
      5'd2, 5'd6, 5'd10: n = NibbleWake;
      5'd13:             n = NibbleFour;
      default:           n = NibbleNone;
    endcase
    return n;
  endfunction

  function automatic logic [ByteWidth-1:0] next_init_byte(input logic [ByteWidth-1:0] b);
    logic [ByteWidth-1:0] r;
    priority if (b == InitFunctionSet) begin
      r = InitDisplayOn;
    end else if (b == InitDisplayOn) begin
      r = InitEntryMode;
    end else begin
      r = InitClear;
    end
    return r;
  endfunction

endpackage

@@ hdl/clns_if.sv @@
// request, result and configuration channel interfaces
interface clns_req_if;
  logic                               valid;
  logic                               ready;
  logic [clns_pkg::OpcodeWidth-1:0]   opcode;
  logic [clns_pkg::ByteWidth-1:0]     byte_value;
  modport source (output valid, output opcode, output byte_value, input ready);
  modport sink   (input valid, input opcode, input byte_value, output ready);
endinterface

interface clns_res_if;
  logic                               valid;
  logic                               ready;
  logic                               register_select;
  logic                               enable_pin;
  logic [clns_pkg::NibbleWidth-1:0]   data_nibble;
  logic                               busy_res;
  logic                               rejected;
  modport source (output valid, output register_select, output enable_pin,
                  output data_nibble, output busy_res, output rejected, input ready);
  modport sink   (input valid, input register_select, input enable_pin,
                  input data_nibble, input busy_res, input rejected, output ready);
endinterface

interface clns_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [clns_pkg::TpuWidth-1:0]      data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/char_lcd_nibble_sequencer.sv @@
// hd44780 style 4-bit lcd bus sequencer: one request per clock tick while no result waits in the skid register
// results: a request's result is registered in the output register, or in the skid register while the output waits
// throughput: one request per cycle while the skid register is empty; it holds one extra result
//   so a request is still taken while one result waits downstream
// reset: sequencer idle, pins low, tick rate 100 per microsecond, no results held
module char_lcd_nibble_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  clns_cfg_if.sink         cfg_i,
  clns_req_if.sink         req_i,
  clns_res_if.source       res_o
);

  logic [clns_pkg::TpuWidth-1:0]    tpu_q;
  logic [clns_pkg::StepWidth-1:0]   step_q, step_d;
  logic [clns_pkg::DelayWidth-1:0]  delay_q, delay_d;
  logic [clns_pkg::ByteWidth-1:0]   held_q, held_d;
  logic                             rs_q, rs_d;
  logic                             en_q, en_d;
  logic [clns_pkg::NibbleWidth-1:0] nib_q, nib_d;
  logic                             init_q, init_d;

  clns_pkg::res_t res_new;
  clns_pkg::res_t out_q, skid_q;
  logic           out_valid_q, skid_valid_q;
  logic           req_acc;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = ~skid_valid_q;
  assign req_acc     = req_i.valid & req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q <= clns_pkg::TpuReset;
    end else if (cfg_i.valid && cfg_i.ready) begin
      tpu_q <= cfg_i.data;
    end
  end

  // next sequencer state for the request in flight
  always_comb begin
    logic [clns_pkg::StepWidth-1:0]   s_next;
    logic                             entered;
    logic                             step_done;
    logic [clns_pkg::DelayWidth-1:0]  delay_inc;
    logic [clns_pkg::DelayWidth-1:0]  dur_ticks;
    logic                             rejected;
    clns_pkg::step_kind_e             kind;

    step_d   = step_q;
    delay_d  = delay_q;
    held_d   = held_q;
    rs_d     = rs_q;
    en_d     = en_q;
    nib_d    = nib_q;
    init_d   = init_q;
    entered  = 1'b0;
    rejected = 1'b0;
    s_next   = step_q;

    delay_inc = delay_q + clns_pkg::DelayWidth'(1);
    dur_ticks = clns_pkg::DelayWidth'(clns_pkg::step_us(step_q)) *
                clns_pkg::DelayWidth'(tpu_q);
    // setup steps and a zero tick rate give zero length and end on the next tick
    step_done = (delay_inc >= dur_ticks);

    if (step_q != clns_pkg::StepIdle) begin
      if (!step_done) begin
        delay_d = delay_inc;
      end else begin
        entered = 1'b1;
        s_next  = step_q + clns_pkg::StepWidth'(1);
        if (step_q >= clns_pkg::StepLast) begin
          if (init_q && (held_q != clns_pkg::InitClear)) begin
            held_d = clns_pkg::next_init_byte(held_q);
            s_next = clns_pkg::StepByteFirst;
          end else begin
            init_d = 1'b0;
            s_next = clns_pkg::StepIdle;
          end
        end else if (step_q == clns_pkg::StepInitLast) begin
          held_d = clns_pkg::InitFunctionSet;
        end
        step_d = s_next;
      end
    end

    if (clns_pkg::opcode_e'(req_i.opcode) != clns_pkg::OpTick) begin
      if (step_d != clns_pkg::StepIdle) begin
        rejected = 1'b1;
      end else if (clns_pkg::opcode_e'(req_i.opcode) == clns_pkg::OpInit) begin
        entered = 1'b1;
        init_d  = 1'b1;
        rs_d    = 1'b0;
        step_d  = clns_pkg::StepInitFirst;
      end else begin
        entered = 1'b1;
        init_d  = 1'b0;
        held_d  = req_i.byte_value;
        rs_d    = (clns_pkg::opcode_e'(req_i.opcode) == clns_pkg::OpData);
        step_d  = clns_pkg::StepByteFirst;
      end
    end

    // pin effects of entering a step
    kind = clns_pkg::step_kind(step_d);
    if (entered) begin
      delay_d = '0;
      unique case (kind)
        clns_pkg::KindSetup: begin
          en_d = 1'b0;
          priority if (step_d == clns_pkg::StepByteFirst) begin
            nib_d = held_d[7:4];
          end else if (step_d > clns_pkg::StepByteFirst) begin
            nib_d = held_d[3:0];
          end else begin
            nib_d = clns_pkg::init_nibble(step_d);
          end
        end
        clns_pkg::KindHigh: en_d = 1'b1;
        clns_pkg::KindLow:  en_d = 1'b0;
        default: ;
      endcase
    end

    res_new.register_select = rs_d;
    res_new.enable_pin      = en_d;
    res_new.data_nibble     = nib_d;
    res_new.busy_res        = (step_d != clns_pkg::StepIdle);
    res_new.rejected        = rejected;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= clns_pkg::StepIdle;
      delay_q <= '0;
      held_q  <= '0;
      rs_q    <= 1'b0;
      en_q    <= 1'b0;
      nib_q   <= '0;
      init_q  <= 1'b0;
    end else if (req_acc) begin
      step_q  <= step_d;
      delay_q <= delay_d;
      held_q  <= held_d;
      rs_q    <= rs_d;
      en_q    <= en_d;
      nib_q   <= nib_d;
      init_q  <= init_d;
    end
  end

  // result register with a skid stage behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_valid_q && !res_o.ready) begin
      if (req_acc) begin
        skid_valid_q <= 1'b1;
      end
    end else if (skid_valid_q) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= req_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && !res_o.ready) begin
      if (req_acc) begin
        skid_q <= res_new;
      end
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else if (req_acc) begin
      out_q <= res_new;
    end
  end

  assign res_o.valid           = out_valid_q;
  assign res_o.register_select = out_q.register_select;
  assign res_o.enable_pin      = out_q.enable_pin;
  assign res_o.data_nibble     = out_q.data_nibble;
  assign res_o.busy_res        = out_q.busy_res;
  assign res_o.rejected        = out_q.rejected;

endmodule
